// ===== rtl/positional_list_insert_delete_defines.svh =====
// assertion macros for the positional list block
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// field widths, operation codes and status codes of the positional list
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int FUNC_W   = 2;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam func_type FN_INSERT = 2'd0;
   localparam func_type FN_DELETE = 2'd1;
   localparam func_type FN_READ   = 2'd2;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_EMPTY  = 2'd2;
   localparam status_type ST_BADPOS = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/pli_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
`default_nettype none
// insert: entries from the position to the top move one place up, then the new value
//   is written; delete: entries above the position move one place down; read-out
//   returns elements in order; one item at a time, req_stall high until its last
//   result is queued; each entry move is a ram read followed by a ram write
// reset: count cleared, element store contents undefined, no clearing pass
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// bounded ordered list of signed values with insert/delete at a position and
// full read-out, entries kept in a single-port-pair ram moved one per step
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete
   import pli_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [FUNC_W-1:0]        req_func,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_new_value,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_element,
   output logic [INDEX_W-1:0]            rsp_element_index,
   output logic [COUNT_W-1:0]            rsp_count_after,
   output logic                          rsp_last
);

   // ram index width and count width (count can reach CAPACITY)
   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   // common width for comparing position against count and for output fields
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;  // fetch entry below the gap
   localparam logic [3:0] S_INS_MOV = 4'd2;  // write it one place up
   localparam logic [3:0] S_INS_PUT = 4'd3;  // drop new value into the gap
   localparam logic [3:0] S_DEL_RD  = 4'd4;  // fetch entry above the hole
   localparam logic [3:0] S_DEL_MOV = 4'd5;  // write it one place down
   localparam logic [3:0] S_OUT_RD  = 4'd6;  // address next element
   localparam logic [3:0] S_OUT_LD  = 4'd7;  // hand element to output register
   localparam logic [3:0] S_RESP    = 4'd8;  // single result for insert/delete/empty

   logic [3:0]               state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            ptr_ff, ptr_in;       // walking index of the sequencer
   logic [CW-1:0]            pos_ff, pos_in;       // checked position of the item
   logic signed [DATA_W-1:0] value_ff, value_in;   // value held for an insert
   status_type               res_status_ff, res_status_in;

   // output register
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_element_ff;
   logic [INDEX_W-1:0]       rsp_element_index_ff;
   logic [COUNT_W-1:0]       rsp_count_after_ff;
   logic                     rsp_last_ff;

   logic                     out_load;
   logic                     out_free;
   status_type               out_status;
   logic signed [DATA_W-1:0] out_element;
   logic [INDEX_W-1:0]       out_index;
   logic                     out_last;

   // ram port signals
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [DATA_W-1:0]        ram_wdata;
   logic [AW-1:0]            ram_raddr;
   logic [DATA_W-1:0]        ram_rdata;

   // helpers
   logic [CMPW-1:0]          pos_ext;
   logic [CMPW-1:0]          count_ext;
   logic [CMPW-1:0]          ptr_ext;
   logic [CW-1:0]            ptr_inc;
   logic [CW-1:0]            ptr_dec;
   logic                     list_full;
   logic                     list_empty;

   assign pos_ext    = CMPW'(req_position);
   assign count_ext  = CMPW'(count_ff);
   assign ptr_ext    = CMPW'(ptr_ff);
   assign ptr_inc    = ptr_ff + CW'(1);
   assign ptr_dec    = ptr_ff - CW'(1);
   assign list_full  = (count_ff == CW'(CAPACITY));
   assign list_empty = (count_ff == '0);

   // output register can take a result this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // one item at a time: take a new item only from idle
   assign req_stall  = (state_ff != S_IDLE);

   pli_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;

      ram_we        = 1'b0;
      ram_waddr     = ptr_ff[AW-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = ptr_ff[AW-1:0];

      out_load      = 1'b0;
      out_status    = ST_OK;
      out_element   = '0;
      out_index     = '0;
      out_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_new_value;
               pos_in   = pos_ext[CW-1:0];
               ptr_in   = count_ff;
               case (req_func)
                  FN_INSERT: begin
                     // full check comes before the position check
                     if (list_full) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else if (pos_ext > count_ext) begin
                        res_status_in = ST_BADPOS;
                        state_in      = S_RESP;
                     end else begin
                        // open a gap from the top down to the position
                        state_in = S_INS_RD;
                     end
                  end
                  FN_DELETE: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else if (pos_ext >= count_ext) begin
                        res_status_in = ST_BADPOS;
                        state_in      = S_RESP;
                     end else begin
                        // close the hole from the position upward
                        ptr_in   = pos_ext[CW-1:0];
                        state_in = S_DEL_RD;
                     end
                  end
                  FN_READ: begin
                     if (list_empty) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_OUT_RD;
                     end
                  end
                  default: begin
                     // unused code: dropped, no result
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (ptr_ff == pos_ff) begin
               state_in = S_INS_PUT;
            end else begin
               ram_raddr = ptr_dec[AW-1:0];
               state_in  = S_INS_MOV;
            end
         end
         S_INS_MOV: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[AW-1:0];
            ram_wdata = ram_rdata;
            ptr_in    = ptr_dec;
            state_in  = S_INS_RD;
         end
         S_INS_PUT: begin
            ram_we        = 1'b1;
            ram_waddr     = pos_ff[AW-1:0];
            ram_wdata     = value_ff;
            count_in      = count_ff + CW'(1);
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end
         S_DEL_RD: begin
            if (ptr_inc >= count_ff) begin
               // reached the top, list shrinks by one
               count_in      = count_ff - CW'(1);
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else begin
               ram_raddr = ptr_inc[AW-1:0];
               state_in  = S_DEL_MOV;
            end
         end
         S_DEL_MOV: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[AW-1:0];
            ram_wdata = ram_rdata;
            ptr_in    = ptr_inc;
            state_in  = S_DEL_RD;
         end
         S_OUT_RD: begin
            ram_raddr = ptr_ff[AW-1:0];
            state_in  = S_OUT_LD;
         end
         S_OUT_LD: begin
            // keep the address so read data holds while the output is busy
            ram_raddr = ptr_ff[AW-1:0];
            if (out_free) begin
               out_load    = 1'b1;
               out_status  = ST_OK;
               out_element = ram_rdata;
               out_index   = ptr_ext[INDEX_W-1:0];
               out_last    = (ptr_inc == count_ff);
               if (ptr_inc == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_inc;
                  state_in = S_OUT_RD;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = res_status_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_status_ff        <= out_status;
         rsp_element_ff       <= out_element;
         rsp_element_index_ff <= out_index;
         rsp_count_after_ff   <= count_ext[COUNT_W-1:0];
         rsp_last_ff          <= out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_index = rsp_element_index_ff;
   assign rsp_count_after   = rsp_count_after_ff;
   assign rsp_last          = rsp_last_ff;

   // checks
   `PLI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
      "element count above capacity")
   `PLI_ASSERT_NOW(a_no_write_in_readout, clock, reset,
      (state_ff == S_OUT_RD) || (state_ff == S_OUT_LD), !ram_we,
      "store written during read-out")
   `PLI_ASSERT_NOW(a_write_in_range, clock, reset, ram_we,
      (state_ff == S_INS_PUT) ? (pos_ff < CW'(CAPACITY)) : (ptr_ff < CW'(CAPACITY)),
      "store write beyond capacity")
   `PLI_ASSERT_NEXT(a_count_step, clock, reset, 1'b1,
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1)) ||
      (count_ff == $past(count_ff) - CW'(1)),
      "element count moved by more than one")
   `PLI_ASSERT_NOW(a_load_when_free, clock, reset, out_load, out_free,
      "result loaded over a waiting result")

endmodule
`default_nettype wire
